[sv/fst_pkg.sv]
`default_nettype none
package fst_pkg;

    localparam int PIX_BITS = 8;
    localparam int THR_BITS = 8;
    localparam int LEN_BITS = 5;

    localparam logic [LEN_BITS-1:0] LEN_MAX        = 5'd31;
    localparam logic [LEN_BITS-1:0] RUN_NEEDED_RST = 5'd12;
    localparam logic [THR_BITS-1:0] THRESHOLD_RST  = 8'd51;

    // configuration register indexes
    localparam logic REG_RUN_NEEDED = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    typedef enum logic [1:0] {
        CLS_SIMILAR  = 2'd0,
        CLS_BRIGHTER = 2'd1,
        CLS_DARKER   = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic last;
    } fst_word_t;

endpackage
`default_nettype wire

[sv/fst_classify.sv]
`default_nettype none
module fst_classify
    import fst_pkg::*;
(
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [PIX_BITS-1:0] center_pixel,
    input  wire logic [PIX_BITS-1:0] ring_pixel,
    input  wire logic                last,
    input  wire logic [THR_BITS-1:0] threshold_q8,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output fst_word_t                push_word
);

    localparam int CMP_BITS = PIX_BITS + THR_BITS + 1;

    logic [PIX_BITS+THR_BITS-1:0] prod;
    logic [CMP_BITS-1:0]          ring_s;
    logic [CMP_BITS-1:0]          center_s;
    logic [CMP_BITS-1:0]          prod_x;
    logic                         brighter;
    logic                         darker;

    // center * (256 +/- t) split as center*256 +/- center*t
    assign prod     = center_pixel * threshold_q8;
    assign prod_x   = {1'b0, prod};
    assign ring_s   = {1'b0, ring_pixel, {THR_BITS{1'b0}}};
    assign center_s = {1'b0, center_pixel, {THR_BITS{1'b0}}};

    assign brighter = ring_s > (center_s + prod_x);
    assign darker   = (ring_s + prod_x) < center_s;

    always_comb begin
        push_word.last = last;
        if (brighter) begin
            push_word.cls = CLS_BRIGHTER;
        end else if (darker) begin
            push_word.cls = CLS_DARKER;
        end else begin
            push_word.cls = CLS_SIMILAR;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule
`default_nettype wire

[sv/fst_queue.sv]
`default_nettype none
module fst_queue
    import fst_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire fst_word_t push_word,
    output logic           q_valid,
    input  wire logic      q_ready,
    output fst_word_t      q_word
);

    fst_word_t              mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = count_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign q_valid    = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = q_valid && q_ready;
    assign q_word     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

[sv/fst_run.sv]
`default_nettype none
module fst_run
    import fst_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [LEN_BITS-1:0] run_needed,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire fst_word_t           q_word,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic                     is_corner
);

    logic [LEN_BITS-1:0] run_length_reg, run_length_next;
    cls_t                run_class_reg, run_class_next;
    logic [LEN_BITS-1:0] lead_length_reg, lead_length_next;
    cls_t                lead_class_reg, lead_class_next;
    logic                lead_open_reg, lead_open_next;
    logic                found_reg, found_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                is_corner_reg, is_corner_next;

    logic [LEN_BITS-1:0] rl;
    cls_t                rc;
    logic [LEN_BITS-1:0] ll;
    cls_t                lc;
    logic                lo;
    logic                fnd;
    logic [LEN_BITS:0]   sum;
    logic [LEN_BITS-1:0] sum_sat;
    logic                wrap_hit;
    logic                pop;

    // hold off while a result waits, so it is never overwritten
    assign q_ready = !m_tvalid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        rl = run_length_reg;
        rc = run_class_reg;
        ll = lead_length_reg;
        lc = lead_class_reg;
        lo = lead_open_reg;

        if (q_word.cls == CLS_SIMILAR) begin
            rl = '0;
            rc = CLS_SIMILAR;
            lo = 1'b0;
        end else if (q_word.cls == run_class_reg && run_length_reg != '0) begin
            if (run_length_reg != LEN_MAX) begin
                rl = run_length_reg + 1'b1;
            end
        end else begin
            if (run_length_reg != '0) begin
                lo = 1'b0;
            end
            rl = LEN_BITS'(1);
            rc = q_word.cls;
        end

        if (lo) begin
            ll = rl;
            lc = rc;
        end

        fnd = found_reg || (rl >= run_needed);

        // run at the end joined with the leading run wraps around the ring
        sum      = {1'b0, rl} + {1'b0, ll};
        sum_sat  = sum[LEN_BITS] ? LEN_MAX : sum[LEN_BITS-1:0];
        wrap_hit = !lo && rc != CLS_SIMILAR && rc == lc && rl != '0 && ll != '0
                   && sum_sat >= run_needed;
    end

    always_comb begin
        run_length_next  = run_length_reg;
        run_class_next   = run_class_reg;
        lead_length_next = lead_length_reg;
        lead_class_next  = lead_class_reg;
        lead_open_next   = lead_open_reg;
        found_next       = found_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        is_corner_next   = is_corner_reg;
        if (pop) begin
            if (q_word.last) begin
                run_length_next  = '0;
                run_class_next   = CLS_SIMILAR;
                lead_length_next = '0;
                lead_class_next  = CLS_SIMILAR;
                lead_open_next   = 1'b1;
                found_next       = 1'b0;
                m_tvalid_next    = 1'b1;
                is_corner_next   = fnd || wrap_hit;
            end else begin
                run_length_next  = rl;
                run_class_next   = rc;
                lead_length_next = ll;
                lead_class_next  = lc;
                lead_open_next   = lo;
                found_next       = fnd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_length_reg  <= '0;
            run_class_reg   <= CLS_SIMILAR;
            lead_length_reg <= '0;
            lead_class_reg  <= CLS_SIMILAR;
            lead_open_reg   <= 1'b1;
            found_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            run_length_reg  <= run_length_next;
            run_class_reg   <= run_class_next;
            lead_length_reg <= lead_length_next;
            lead_class_reg  <= lead_class_next;
            lead_open_reg   <= lead_open_next;
            found_reg       <= found_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_corner_reg <= is_corner_next;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign is_corner = is_corner_reg;

endmodule
`default_nettype wire

[sv/fast_segment_test.sv]
// Segment-test corner decision, one ring pixel per word.
// Input stream (s_): one word per ring pixel in circle order, center value
// repeated on every word, s_tlast on the final ring pixel of a candidate.
// Output stream (m_): one word per candidate, sent after its s_tlast word;
// m_tdata bit 0 is the corner flag.
// Config channel (cfg_): index 0 run_needed, index 1 threshold_q8
// (fraction of 256); always ready, write only between candidates.
// Throughput: one ring pixel per cycle while no result is stalled, set by the
// combinational classifier and registered run update.
// Path: the last word of a candidate is classified into a 2-word queue, then
// popped by the run update, which registers the result and raises m_tvalid.
// Reset clears run state, the queue and m_tvalid, and loads run_needed = 12,
// threshold_q8 = 51.
// When m_tready is low the result holds; the run unit stops, the queue fills
// and s_tready drops once the queue holds two words.
`default_nettype none
module fast_segment_test
    import fst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] center_pixel, [15:8] ring_pixel
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] is_corner, [7:1] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [LEN_BITS-1:0] run_needed_reg;
    logic [THR_BITS-1:0] threshold_q8_reg;
    logic                push_valid;
    logic                push_ready;
    fst_word_t           push_word;
    logic                q_valid;
    logic                q_ready;
    fst_word_t           q_word;
    logic                is_corner;
    logic                pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_needed_reg   <= RUN_NEEDED_RST;
            threshold_q8_reg <= THRESHOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_RUN_NEEDED) begin
                run_needed_reg <= cfg_data[LEN_BITS-1:0];
            end
            if (cfg_index == REG_THRESHOLD) begin
                threshold_q8_reg <= cfg_data[THR_BITS-1:0];
            end
        end
    end

    fst_classify u_classify (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .center_pixel (s_tdata[PIX_BITS-1:0]),
        .ring_pixel   (s_tdata[2*PIX_BITS-1:PIX_BITS]),
        .last         (s_tlast),
        .threshold_q8 (threshold_q8_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_word    (push_word)
    );

    fst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_word     (q_word)
    );

    fst_run u_run (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .run_needed (run_needed_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_word     (q_word),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .is_corner  (is_corner)
    );

    assign m_tdata = {7'd0, is_corner};
    assign pop     = q_valid && q_ready;

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_word.last) |=> m_tvalid)
        else $error("no result after last word");

    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !pop)
        else $error("queue popped while result stalled");

    a_accept_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> q_valid)
        else $error("accepted word missing from queue");
`endif

endmodule
`default_nettype wire
